>>> src/tsc_pkg.sv
package tsc_pkg;

   localparam logic [7:0] PULSE_FRAME_TICKS    = 8'd15;
   localparam logic [7:0] FAST_CAL_FRAME_TICKS = 8'd128;
   localparam logic [7:0] SLOW_CAL_FRAME_TICKS = 8'd255;
   localparam logic [7:0] REACQUIRE_EDGES      = 8'd200;
   localparam logic [15:0] NOT_CAL             = 16'hFFFF;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_EDGE  = 2'd2;
   localparam logic [1:0] REQ_CTRL  = 2'd3;

   localparam logic [1:0] MODE_FAST    = 2'd0;
   localparam logic [1:0] MODE_SLOW    = 2'd1;
   localparam logic [1:0] MODE_NOPULSE = 2'd2;
   localparam logic [1:0] MODE_RUN     = 2'd3;

   localparam logic CSR_FAST = 1'b0;
   localparam logic CSR_SLOW = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] period;
      logic        button;
      logic        timeout;
      logic        adc_valid;
      logic [7:0]  adc_value;
   } req_type_type;

   typedef struct packed {
      logic        servo_level;
      logic        reload_valid;
      logic [7:0]  reload_value;
      logic        led;
      logic [1:0]  mode_now;
      logic        store_valid;
      logic [15:0] store_fast;
      logic [15:0] store_slow;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step;       // apply the transaction's state update
      logic div_start;  // begin a serial division
      logic div_step;   // one quotient bit
      logic scale_go;   // begin scale derivation then division
      logic pulse_sel;  // divider runs for the pulse mapping
   } cmd_type;

   typedef struct packed {
      logic need_scale;  // step needs a span divide
      logic need_pulse;  // step needs a pulse divide
      logic div_done;
   } status_type;

endpackage

>>> src/tach_to_servo_controller_top.sv
// Tachometer to servo controller. One result transaction follows each request
// transaction. Most requests pass through the decide and step states; a
// control step that maps a period by division, and a start or slow-calibration
// exit that derives the scale, also pass through the load state and the 16-step
// serial divider. A finished result waits in its output register while the next
// request is taken in; the update of that next request holds until the waiting
// result has been accepted. The saved periods are written through the csr_ port
// and take effect on the next start request.
module tach_to_servo_controller_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tsc_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tsc_pkg::rsp_type      rsp_data,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [15:0]           csr_write_data
);
   import tsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   tsc_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status), .cmd(cmd)
   );

   tsc_datapath u_dp (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data), .req_data(req_data),
      .req_load(req_valid & req_ready), .cmd(cmd), .status(status),
      .rsp_data(rsp_data)
   );

endmodule

>>> src/tsc_datapath.sv
module tsc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [15:0]           csr_write_data,
   input  tsc_pkg::req_type_type req_data,
   input  logic                  req_load,
   input  tsc_pkg::cmd_type      cmd,
   output tsc_pkg::status_type   status,
   output tsc_pkg::rsp_type      rsp_data
);
   import tsc_pkg::*;

   logic [15:0] saved_fast_ff, saved_slow_ff;
   req_type_type req_ff;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  frame_count_ff, frame_count_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  pulse_ff, pulse_in;
   logic [15:0] latched_ff, latched_in;
   logic        pending_ff, pending_in;
   logic [15:0] fast_ff, fast_in, slow_ff, slow_in;
   logic [8:0]  scale_ff, scale_in;
   logic        mult_ff, mult_in;
   logic [7:0]  edge_count_ff, edge_count_in;
   logic        led_ff, led_in, servo_ff, servo_in;
   rsp_type     rsp_in;

   // Serial restoring divider: numerator, denominator, remainder, bit count.
   logic [15:0] num_ff, num_in;
   logic [15:0] den_ff, den_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [15:0] span, clamped, diff;
   logic [16:0] rem_shift, sum17;
   logic [16:0] product;
   logic        going_pulse;

   always_comb begin
      span = slow_ff - fast_ff;
      clamped = latched_ff;
      if (clamped < fast_ff) clamped = fast_ff;
      if (clamped > slow_ff) clamped = slow_ff;
      diff = (clamped > fast_ff) ? clamped - fast_ff : 16'd0;
      product = {1'b0, diff[7:0]} * scale_ff;
   end

   always_comb begin
      status.need_pulse = (req_ff.req_type == REQ_CTRL) && (mode_ff == MODE_RUN)
         && pending_ff && !mult_ff && (scale_ff != 9'd0);
      going_pulse = 1'b0;
      if (req_ff.req_type == REQ_START)
         going_pulse = (saved_fast_ff != NOT_CAL) && (saved_slow_ff != NOT_CAL);
      else if (req_ff.req_type == REQ_CTRL && mode_ff == MODE_SLOW)
         going_pulse = !req_ff.button && (slow_ff != 16'd0);
      status.need_scale = going_pulse;
      status.div_done = (cnt_ff == 5'd0);
   end

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      rem_shift = {rem_ff[15:0], num_ff[15]};
      if (cmd.div_start) begin
         rem_in = 17'd0;
         cnt_in = 5'd16;
         if (cmd.pulse_sel) begin
            num_in = diff;
            den_in = {7'd0, scale_ff};
         end else begin
            num_in = 16'd256;
            den_in = span;
         end
      end else if (cmd.div_step && cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_shift - {1'b0, den_ff};
            num_in = {num_ff[14:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            num_in = {num_ff[14:0], 1'b0};
         end
      end
   end

   always_comb begin
      mode_in = mode_ff;
      frame_count_in = frame_count_ff;
      frame_length_in = frame_length_ff;
      pulse_in = pulse_ff;
      latched_in = latched_ff;
      pending_in = pending_ff;
      fast_in = fast_ff;
      slow_in = slow_ff;
      scale_in = scale_ff;
      mult_in = mult_ff;
      edge_count_in = edge_count_ff;
      led_in = led_ff;
      servo_in = servo_ff;
      rsp_in = '0;
      sum17 = {1'b0, fast_ff} + {1'b0, latched_ff};
      if (cmd.scale_go) begin
         if (req_ff.req_type == REQ_START) begin
            fast_in = saved_fast_ff;
            slow_in = saved_slow_ff;
         end
      end else if (cmd.step) begin
         case (req_ff.req_type)
            REQ_START: begin
               pending_in = 1'b0;
               if (going_pulse) begin
                  mode_in = MODE_RUN;
                  frame_length_in = PULSE_FRAME_TICKS;
               end else begin
                  fast_in = 16'd0;
                  slow_in = 16'd0;
                  mode_in = MODE_FAST;
                  frame_length_in = FAST_CAL_FRAME_TICKS;
               end
            end
            REQ_TICK: begin
               frame_count_in = frame_count_ff + 8'd1;
               if (frame_count_in >= frame_length_ff) begin
                  frame_count_in = 8'd0;
                  servo_in = 1'b1;
               end else if (frame_count_in == 8'd1) begin
                  rsp_in.reload_valid = 1'b1;
                  rsp_in.reload_value = pulse_ff;
               end else if (frame_count_in == 8'd2) begin
                  servo_in = 1'b0;
               end
            end
            REQ_EDGE: begin
               if (!pending_ff) begin
                  latched_in = req_ff.period;
                  pending_in = 1'b1;
               end
            end
            default: begin
               case (mode_ff)
                  MODE_FAST: begin
                     led_in = !(frame_count_ff > (FAST_CAL_FRAME_TICKS >> 2));
                     pending_in = 1'b0;
                     if (req_ff.button) begin
                        if (pending_ff)
                           fast_in = (fast_ff == 16'd0) ? latched_ff : sum17[16:1];
                     end else if (fast_ff != 16'd0) begin
                        mode_in = MODE_SLOW;
                        frame_length_in = SLOW_CAL_FRAME_TICKS;
                     end
                  end
                  MODE_SLOW: begin
                     led_in = !(frame_count_ff > (SLOW_CAL_FRAME_TICKS >> 2));
                     pending_in = 1'b0;
                     sum17 = {1'b0, slow_ff} + {1'b0, latched_ff};
                     if (req_ff.button) begin
                        if (pending_ff)
                           slow_in = (slow_ff == 16'd0) ? latched_ff : sum17[16:1];
                     end else if (slow_ff != 16'd0) begin
                        rsp_in.store_valid = 1'b1;
                        rsp_in.store_fast = fast_ff;
                        rsp_in.store_slow = slow_ff;
                        mode_in = MODE_RUN;
                        frame_length_in = PULSE_FRAME_TICKS;
                     end
                  end
                  MODE_RUN: begin
                     if (pending_ff) begin
                        pending_in = 1'b0;
                        if (mult_ff)
                           pulse_in = (diff[15:8] != 8'd0 || product[16:8] != 9'd0)
                              ? 8'd255 : product[7:0];
                        else if (scale_ff == 9'd0)
                           pulse_in = (diff > 16'd255) ? 8'd255 : diff[7:0];
                        else
                           pulse_in = (num_ff > 16'd255) ? 8'd255 : num_ff[7:0];
                     end else if (req_ff.timeout) begin
                        mode_in = MODE_NOPULSE;
                        edge_count_in = 8'd0;
                     end
                  end
                  default: begin
                     if (pending_ff) begin
                        pending_in = 1'b0;
                        if (edge_count_ff >= REACQUIRE_EDGES)
                           mode_in = MODE_RUN;
                        else
                           edge_count_in = edge_count_ff + 8'd1;
                     end else if (req_ff.timeout) begin
                        edge_count_in = 8'd0;
                     end
                  end
               endcase
               if (req_ff.adc_valid && mode_in != MODE_RUN)
                  pulse_in = req_ff.adc_value;
            end
         endcase
         if (going_pulse) begin
            if (span < 16'd256) begin
               scale_in = (span == 16'd0) ? 9'd256 : num_ff[8:0];
               mult_in = 1'b1;
            end else begin
               scale_in = {1'b0, span[15:8]};
               mult_in = 1'b0;
            end
         end
         rsp_in.servo_level = servo_in;
         rsp_in.led = led_in;
         rsp_in.mode_now = mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saved_fast_ff <= NOT_CAL;
         saved_slow_ff <= NOT_CAL;
         mode_ff <= MODE_FAST;
         frame_count_ff <= 8'd0;
         frame_length_ff <= FAST_CAL_FRAME_TICKS;
         pulse_ff <= 8'd0;
         latched_ff <= 16'd0;
         pending_ff <= 1'b0;
         fast_ff <= 16'd0;
         slow_ff <= 16'd0;
         scale_ff <= 9'd1;
         mult_ff <= 1'b1;
         edge_count_ff <= 8'd0;
         led_ff <= 1'b0;
         servo_ff <= 1'b0;
         cnt_ff <= 5'd0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_FAST) saved_fast_ff <= csr_write_data;
            else saved_slow_ff <= csr_write_data;
         end
         mode_ff <= mode_in;
         frame_count_ff <= frame_count_in;
         frame_length_ff <= frame_length_in;
         pulse_ff <= pulse_in;
         latched_ff <= latched_in;
         pending_ff <= pending_in;
         fast_ff <= fast_in;
         slow_ff <= slow_in;
         scale_ff <= scale_in;
         mult_ff <= mult_in;
         edge_count_ff <= edge_count_in;
         led_ff <= led_in;
         servo_ff <= servo_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) req_ff <= req_data;
      if (cmd.step) rsp_data <= rsp_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

endmodule

>>> src/tsc_controller.sv
module tsc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tsc_pkg::status_type status,
   output tsc_pkg::cmd_type    cmd
);
   import tsc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_STEP   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       pulse_ff, pulse_in;
   logic       out_ff, out_in;

   always_comb begin
      state_in = state_ff;
      pulse_in = pulse_ff;
      out_in = out_ff;
      cmd = '0;
      cmd.pulse_sel = pulse_ff;
      req_ready = (state_ff == ST_IDLE);
      if (out_ff && rsp_ready) out_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.need_scale) begin
               cmd.scale_go = 1'b1;
               pulse_in = 1'b0;
               state_in = ST_LOAD;
            end else if (status.need_pulse) begin
               pulse_in = 1'b1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (!out_ff || rsp_ready) begin
               cmd.step = 1'b1;
               out_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pulse_ff <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pulse_ff <= pulse_in;
         out_ff <= out_in;
      end
   end

endmodule
